FILE: rtl/i2cm_pkg.sv
// Shared types, constants and decode function for the I2C master bit engine.
package i2cm_pkg;

  // Widths and defaults
  localparam int unsigned WORD_BITS_DEF = 16;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned RD_W          = 16;
  localparam int unsigned BYTE_BITS     = 8;

  // Register reset values
  localparam logic [CNT_W-1:0] HALF_RST      = 16'd5;
  localparam logic [CNT_W-1:0] READ_HALF_RST = 16'd1;
  localparam logic [CNT_W-1:0] ACK_TO_RST    = 16'd5000;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_HALF      = 2'd0;
  localparam logic [1:0] REG_READ_HALF = 2'd1;
  localparam logic [1:0] REG_ACK_TO    = 2'd2;

  // Operation codes as they arrive on the input
  localparam logic [2:0] OPC_NONE      = 3'd0;
  localparam logic [2:0] OPC_START     = 3'd1;
  localparam logic [2:0] OPC_STOP      = 3'd2;
  localparam logic [2:0] OPC_WRITE     = 3'd3;
  localparam logic [2:0] OPC_READ_BYTE = 3'd4;
  localparam logic [2:0] OPC_READ_WORD = 3'd5;

  // Classified command carried through the queue
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ_BYTE,
    CMD_READ_WORD
  } cmd_t;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_STOP,
    PH_WR_DATA,
    PH_WR_CLK,
    PH_ACK_HIGH,
    PH_ACK_POLL,
    PH_ACK_TAIL,
    PH_RD_LOW,
    PH_RD_HIGH
  } phase_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic            scl_level;
    logic            sda_level;
    logic            sda_released;
    logic            busy_res;
    logic [RD_W-1:0] read_value;
    logic            read_done;
    logic            ack_missing;
  } out_item_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wdata;
    logic       pin;
  } q_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] half_period;
    logic [CNT_W-1:0] read_half;
    logic [CNT_W-1:0] ack_timeout;
  } cfg_t;

  // Map the raw operation code; unknown codes act as no command
  function automatic cmd_t classify(input logic [2:0] op);
    cmd_t c;
    case (op)
      OPC_START:     c = CMD_START;
      OPC_STOP:      c = CMD_STOP;
      OPC_WRITE:     c = CMD_WRITE;
      OPC_READ_BYTE: c = CMD_READ_BYTE;
      OPC_READ_WORD: c = CMD_READ_WORD;
      default:       c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/i2cm_front.sv
// Input side: takes requests, classifies the operation and queues them.
module i2cm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cm_pkg::in_item_t in_data,
  output logic               q_valid,
  output i2cm_pkg::q_item_t  q_item,
  input  logic               q_pop
);

  i2cm_pkg::q_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Queue storage, classified on entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{cmd:   i2cm_pkg::classify(in_data.operation),
                       wdata: in_data.write_data,
                       pin:   in_data.sda_sample};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/i2cm_back.sv
// Bus sequencer: runs one tick per queued request and registers the result.
module i2cm_back #(
  parameter int unsigned WORD_BITS = i2cm_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  i2cm_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  i2cm_pkg::q_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_data
);

  localparam int unsigned BW = $clog2(WORD_BITS + 1);
  localparam int unsigned CW = i2cm_pkg::CNT_W;
  localparam int unsigned RW = i2cm_pkg::RD_W;
  localparam logic [BW-1:0] WORD_LEN = BW'(WORD_BITS);
  localparam logic [BW-1:0] BYTE_LEN = BW'(i2cm_pkg::BYTE_BITS);
  localparam logic [CW-1:0] CNT_MAX  = '1;

  i2cm_pkg::phase_t phase, phase_next;
  logic [CW-1:0] tick_count, tick_count_next;
  logic [BW-1:0] bit_count, bit_count_next;
  logic [RW-1:0] shift_data, shift_data_next;
  logic [CW-1:0] ack_wait_count, ack_wait_count_next;
  logic scl_reg, scl_reg_next;
  logic sda_reg, sda_reg_next;
  logic sda_release_reg, sda_release_reg_next;
  logic ack_lost, ack_lost_next;
  logic rd_word, rd_word_next;

  logic          adv;
  logic [CW-1:0] lim, lim1, tick_inc, ack_inc, ack_lim1;
  logic          over;
  logic [BW-1:0] bit_inc;
  logic [BW-1:0] read_len;
  logic [RW-1:0] rd_val;
  logic          rd_done, missing;

  // Advance one tick when a request is queued and the result slot frees up
  assign adv   = q_valid && (!out_valid || out_ready);
  assign q_pop = adv;

  // Step timer: saturating count against the phase limit (zero acts as one)
  assign lim      = (phase == i2cm_pkg::PH_RD_LOW || phase == i2cm_pkg::PH_RD_HIGH)
                    ? cfg.read_half : cfg.half_period;
  assign lim1     = (lim == '0) ? CW'(1) : lim;
  assign tick_inc = (tick_count == CNT_MAX) ? tick_count : tick_count + CW'(1);
  assign over     = (tick_inc >= lim1);
  assign bit_inc  = bit_count + BW'(1);
  assign ack_inc  = (ack_wait_count == CNT_MAX) ? ack_wait_count
                    : ack_wait_count + CW'(1);
  assign ack_lim1 = (cfg.ack_timeout == '0) ? CW'(1) : cfg.ack_timeout;
  assign read_len = rd_word ? WORD_LEN : BYTE_LEN;

  // Next state and per-tick result
  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    bit_count_next       = bit_count;
    shift_data_next      = shift_data;
    ack_wait_count_next  = ack_wait_count;
    scl_reg_next         = scl_reg;
    sda_reg_next         = sda_reg;
    sda_release_reg_next = sda_release_reg;
    ack_lost_next        = ack_lost;
    rd_word_next         = rd_word;
    rd_val               = '0;
    rd_done              = 1'b0;
    missing              = 1'b0;
    case (phase)
      i2cm_pkg::PH_IDLE: begin
        tick_count_next = '0;
        bit_count_next  = '0;
        case (q_item.cmd)
          i2cm_pkg::CMD_START: begin
            phase_next   = i2cm_pkg::PH_START;
            sda_reg_next = 1'b1;
          end
          i2cm_pkg::CMD_STOP: begin
            phase_next   = i2cm_pkg::PH_STOP;
            sda_reg_next = 1'b0;
          end
          i2cm_pkg::CMD_WRITE: begin
            phase_next          = i2cm_pkg::PH_WR_DATA;
            shift_data_next     = RW'(q_item.wdata);
            sda_reg_next        = q_item.wdata[7];
            ack_lost_next       = 1'b0;
            ack_wait_count_next = '0;
          end
          i2cm_pkg::CMD_READ_BYTE, i2cm_pkg::CMD_READ_WORD: begin
            phase_next           = i2cm_pkg::PH_RD_LOW;
            rd_word_next         = (q_item.cmd == i2cm_pkg::CMD_READ_WORD);
            shift_data_next      = '0;
            sda_release_reg_next = 1'b1;
            scl_reg_next         = 1'b0;
          end
          default: ;
        endcase
      end
      i2cm_pkg::PH_START: begin
        tick_count_next = over ? '0 : tick_inc;
        if (over) begin
          bit_count_next = bit_inc;
          case (bit_inc)
            BW'(1):  scl_reg_next = 1'b1;
            BW'(2):  sda_reg_next = 1'b0;
            BW'(3):  scl_reg_next = 1'b0;
            default: begin
              bit_count_next = '0;
              phase_next     = i2cm_pkg::PH_IDLE;
            end
          endcase
        end
      end
      i2cm_pkg::PH_STOP: begin
        tick_count_next = over ? '0 : tick_inc;
        if (over) begin
          bit_count_next = bit_inc;
          case (bit_inc)
            BW'(1):  scl_reg_next = 1'b1;
            BW'(2):  sda_reg_next = 1'b1;
            default: begin
              bit_count_next = '0;
              phase_next     = i2cm_pkg::PH_IDLE;
            end
          endcase
        end
      end
      i2cm_pkg::PH_WR_DATA: begin
        tick_count_next = over ? '0 : tick_inc;
        if (over) begin
          scl_reg_next = 1'b1;
          phase_next   = i2cm_pkg::PH_WR_CLK;
        end
      end
      i2cm_pkg::PH_WR_CLK: begin
        tick_count_next = over ? '0 : tick_inc;
        if (over) begin
          shift_data_next = {{(RW-8){1'b0}}, shift_data[6:0], 1'b0};
          bit_count_next  = bit_inc;
          if (bit_inc >= BYTE_LEN) begin
            // SCL stays high into the acknowledge slot, SDA let go
            scl_reg_next         = 1'b1;
            sda_release_reg_next = 1'b1;
            phase_next           = i2cm_pkg::PH_ACK_HIGH;
          end else begin
            scl_reg_next = 1'b0;
            sda_reg_next = shift_data[6];
            phase_next   = i2cm_pkg::PH_WR_DATA;
          end
        end
      end
      i2cm_pkg::PH_ACK_HIGH: begin
        tick_count_next = over ? '0 : tick_inc;
        if (over) begin
          ack_wait_count_next = '0;
          phase_next          = i2cm_pkg::PH_ACK_POLL;
        end
      end
      i2cm_pkg::PH_ACK_POLL: begin
        // Poll the pin until it goes low or the wait runs out
        if (!q_item.pin || ack_inc >= ack_lim1) begin
          if (q_item.pin) ack_lost_next = 1'b1;
          scl_reg_next         = 1'b0;
          sda_release_reg_next = 1'b0;
          tick_count_next      = '0;
          phase_next           = i2cm_pkg::PH_ACK_TAIL;
        end
        if (q_item.pin) ack_wait_count_next = ack_inc;
      end
      i2cm_pkg::PH_ACK_TAIL: begin
        tick_count_next = over ? '0 : tick_inc;
        if (over) begin
          missing        = ack_lost;
          ack_lost_next  = 1'b0;
          bit_count_next = '0;
          phase_next     = i2cm_pkg::PH_IDLE;
        end
      end
      i2cm_pkg::PH_RD_LOW: begin
        tick_count_next = over ? '0 : tick_inc;
        if (over) begin
          scl_reg_next = 1'b1;
          phase_next   = i2cm_pkg::PH_RD_HIGH;
        end
      end
      i2cm_pkg::PH_RD_HIGH: begin
        tick_count_next = over ? '0 : tick_inc;
        if (over) begin
          shift_data_next = {shift_data[RW-2:0], q_item.pin};
          bit_count_next  = bit_inc;
          scl_reg_next    = 1'b0;
          if (bit_inc >= read_len) begin
            sda_release_reg_next = 1'b0;
            rd_done              = 1'b1;
            rd_val               = {shift_data[RW-2:0], q_item.pin};
            bit_count_next       = '0;
            phase_next           = i2cm_pkg::PH_IDLE;
          end else begin
            phase_next = i2cm_pkg::PH_RD_LOW;
          end
        end
      end
      default: phase_next = i2cm_pkg::PH_IDLE;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cm_pkg::PH_IDLE;
      tick_count      <= '0;
      bit_count       <= '0;
      shift_data      <= '0;
      ack_wait_count  <= '0;
      scl_reg         <= 1'b1;
      sda_reg         <= 1'b1;
      sda_release_reg <= 1'b0;
      ack_lost        <= 1'b0;
      rd_word         <= 1'b0;
    end else if (adv) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      bit_count       <= bit_count_next;
      shift_data      <= shift_data_next;
      ack_wait_count  <= ack_wait_count_next;
      scl_reg         <= scl_reg_next;
      sda_reg         <= sda_reg_next;
      sda_release_reg <= sda_release_reg_next;
      ack_lost        <= ack_lost_next;
      rd_word         <= rd_word_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= '{scl_level:    scl_reg_next,
                    sda_level:    sda_reg_next,
                    sda_released: sda_release_reg_next,
                    busy_res:     (phase_next != i2cm_pkg::PH_IDLE),
                    read_value:   rd_val,
                    read_done:    rd_done,
                    ack_missing:  missing};
    end
  end

endmodule

FILE: rtl/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: register port, request queue, sequencer.
//
//   port group   dir  handshake          payload
//   in_*         in   in_valid/in_ready  in_data  (operation, write_data, sda_sample)
//   out_*        out  out_valid/out_ready out_data (bus levels, busy, read/ack status)
//   apb p*       in/out psel/penable     paddr, pwdata, prdata (3 timing registers)
//
// One request per clock while the output is not stalled: each request is one bus
// tick, and the sequencer retires one tick per cycle from a two-entry queue.
// An accepted request passes through a queue entry and then the result register.
// Reset (rst, synchronous) empties the queue, idles the sequencer, sets
// SCL/SDA high and loads the register defaults; no clearing pass.
// A stalled output holds the result; the queue keeps accepting until full.
module i2c_master_bit_engine_core #(
  parameter int unsigned WORD_BITS = i2cm_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  i2cm_pkg::cfg_t    cfg;
  i2cm_pkg::q_item_t q_item;
  logic              q_valid;
  logic              q_pop;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= i2cm_pkg::HALF_RST;
      cfg.read_half   <= i2cm_pkg::READ_HALF_RST;
      cfg.ack_timeout <= i2cm_pkg::ACK_TO_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        i2cm_pkg::REG_HALF:      cfg.half_period <= pwdata[15:0];
        i2cm_pkg::REG_READ_HALF: cfg.read_half   <= pwdata[15:0];
        i2cm_pkg::REG_ACK_TO:    cfg.ack_timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      i2cm_pkg::REG_HALF:      prdata = {16'd0, cfg.half_period};
      i2cm_pkg::REG_READ_HALF: prdata = {16'd0, cfg.read_half};
      i2cm_pkg::REG_ACK_TO:    prdata = {16'd0, cfg.ack_timeout};
      default:                 prdata = '0;
    endcase
  end

  i2cm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  i2cm_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
module i2cm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input i2cm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input i2cm_pkg::out_item_t out_data
);

  // A waiting request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Read completion drops SCL, retakes SDA and ends busy
  a_read_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_done |->
      !out_data.scl_level && !out_data.sda_released && !out_data.busy_res)
    else $error("bad bus state on read completion");

  // Missing acknowledge only reported when the write has finished
  a_ack_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ack_missing |-> !out_data.busy_res && !out_data.read_done)
    else $error("ack flag outside write completion");

  // Read data is zero except on the completion tick
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.read_done |-> out_data.read_value == '0)
    else $error("read data outside completion");

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
